// ----- sv/brsh_pkg.sv -----
// Package for the byte range sample histogram.
// Holds field widths, default sizes, the item structs and the control structs.
// No dependencies.
package brsh_pkg;

  localparam int unsigned DEF_MAX_BYTES    = 1024;
  localparam int unsigned DEF_COUNTER_BITS = 48;

  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned SPAN_W   = 11;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned POS_W    = 17;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [SPAN_W-1:0]   span_bytes;
    logic [COUNT_W-1:0]  sample_count;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] range_max;
    logic [OUT_W-1:0] total_count;
    logic [OUT_W-1:0] unknown_count;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic walk;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic stop;
  } dp_sts_t;

endpackage

// ----- sv/byte_range_sample_histogram.sv -----
// The result strobe follows the walk over the bytes of the item:
// the add span up to the buffer end, or the clamped query length.
// The counter memory is read once per cycle, which sets one byte per cycle.
// A new start is taken in the cycle of the strobe, but not while a walk runs.
// After reset a clearing pass writes zero to every counter memory word, with busy high.
// Results cannot be stalled by the receiver.
module byte_range_sample_histogram
  import brsh_pkg::*;
#(
  parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES,
  parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  brsh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  brsh_dp #(
    .MAX_BYTES    (MAX_BYTES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule

// ----- sv/brsh_ctrl.sv -----
// Controller for the byte range sample histogram.
// Sequences the clearing pass, the per-byte walk and the result strobe.
// Depends on brsh_pkg.
module brsh_ctrl
  import brsh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy      = state_r inside {ST_CLEAR, ST_WALK};
  assign out_valid = (state_r == ST_DONE);
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.stop) begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/brsh_dp.sv -----
// Datapath for the byte range sample histogram.
// Holds the counter memory, the total and unknown counters and the walk pointer.
// Depends on brsh_pkg.
module brsh_dp
  import brsh_pkg::*;
#(
  parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES,
  parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  in_item_t          in_item,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  output out_item_t         out_item
);

  localparam int unsigned ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CB     = COUNTER_BITS;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                            input logic [COUNT_W-1:0] b);
    logic [CB:0] sum;
    sum = {1'b0, a} + (CB+1)'(b);
    return sum[CB] ? {CB{1'b1}} : sum[CB-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [CB-1:0] a);
    logic [63:0] wide;
    wide = 64'(a);
    return wide[OUT_W-1:0];
  endfunction

  logic [CB-1:0]      mem [MAX_BYTES];
  logic [CB-1:0]      rd_data_r;
  logic [SIZE_W-1:0]  size_r;
  logic [CB-1:0]      total_r;
  logic [CB-1:0]      unknown_r;
  logic [CB-1:0]      max_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   end_r;
  logic [COUNT_W-1:0] count_r;
  logic               kind_r;
  logic               pend_r;
  logic [ADDR_W-1:0]  wr_addr_r;
  logic [ADDR_W-1:0]  clr_r;
  logic [POS_W-1:0]   eff_size;
  logic               past_end;
  logic               past_size;
  logic               issue;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [CB-1:0]      mem_wd;

  assign eff_size  = (POS_W'(size_r) > POS_W'(MAX_BYTES)) ? POS_W'(MAX_BYTES)
                                                           : POS_W'(size_r);
  assign past_end  = (pos_r >= end_r);
  assign past_size = (pos_r >= eff_size);
  assign issue     = cmd.walk && !past_end && !past_size;

  assign sts.stop     = past_end || past_size;
  assign sts.clr_last = (clr_r == ADDR_W'(MAX_BYTES - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_r;
    mem_wd = sat_add(rd_data_r, count_r);
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (pend_r && (kind_r == KIND_ADD)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data_r <= mem[pos_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_RESET;
      total_r   <= '0;
      unknown_r <= '0;
      max_r     <= '0;
      pend_r    <= 1'b0;
      clr_r     <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      pend_r <= issue;
      if (cmd.load) begin
        max_r <= '0;
        if (in_item.kind == KIND_ADD) begin
          total_r <= sat_add(total_r, in_item.sample_count);
        end
      end else if (pend_r && (kind_r == KIND_QUERY) && (rd_data_r > max_r)) begin
        max_r <= rd_data_r;
      end
      if (cmd.walk && !past_end && past_size && (kind_r == KIND_ADD)) begin
        unknown_r <= sat_add(unknown_r, count_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_item.kind;
      count_r <= in_item.sample_count;
      pos_r   <= POS_W'(in_item.start_offset);
      end_r   <= POS_W'(in_item.start_offset) + POS_W'(in_item.span_bytes);
    end else if (issue) begin
      pos_r <= pos_r + POS_W'(1);
    end
    if (issue) begin
      wr_addr_r <= pos_r[ADDR_W-1:0];
    end
  end

  assign out_item.range_max     = to_out(max_r);
  assign out_item.total_count   = to_out(total_r);
  assign out_item.unknown_count = to_out(unknown_r);

`ifndef SYNTHESIS
  a_pend_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(cmd.walk))
    else $error("Read data pending without a walk step.");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && (kind_r == KIND_ADD)) |-> (POS_W'(wr_addr_r) < eff_size))
    else $error("Counter write beyond the buffer size.");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clear |=> (total_r >= $past(total_r)))
    else $error("Total counter decreased.");

  a_no_clear_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> !cmd.clear && !pend_r || !cmd.clear)
    else $error("Clearing pass overlaps a walk.");
`endif

endmodule
